### hw/rtl/irts_pkg.sv
// irts_pkg: request and result types, action and status codes
// shared by the sequencer, its channel interface users and its checker
package irts_pkg;

    localparam logic [2:0] ACT_START    = 3'd0;
    localparam logic [2:0] ACT_TX_READY = 3'd1;
    localparam logic [2:0] ACT_RX_BYTE  = 3'd2;
    localparam logic [2:0] ACT_FAULT    = 3'd3;
    localparam logic [2:0] ACT_BUF_WR   = 3'd4;
    localparam logic [2:0] ACT_BUF_RD   = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FAULT      = 2'd1;
    localparam logic [1:0] ST_UNEXPECTED = 2'd2;
    localparam logic [1:0] ST_BUSY       = 2'd3;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] reg_address;
        logic [5:0] byte_count;
        logic       is_send;
        logic [7:0] rx_data;
        logic [2:0] fault_kind;
        logic [4:0] buf_addr;
        logic [7:0] buf_wdata;
    } irts_req_t;

    typedef struct packed {
        logic       tx_load;
        logic [7:0] tx_byte;
        logic       request_start;
        logic       request_stop;
        logic       receive_mode;
        logic       done_res;
        logic [1:0] status;
        logic [2:0] fault_code;
        logic [7:0] read_data;
    } irts_res_t;

endpackage

### hw/rtl/irts_chan_if.sv
// irts_chan_if: valid/ready channel carrying one payload of type T
// no dependencies; payload types come from irts_pkg at instantiation
interface irts_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/irts_ram.sv
// irts_ram: generic single write port, single read port ram, registered read
// no dependencies
module irts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hw/rtl/i2c_register_transfer_sequencer.sv
// i2c_register_transfer_sequencer: i2c master register transaction sequencer
// depends on irts_pkg, irts_chan_if and irts_ram (data buffer)
//
//   channel | dir | payload     | handshake
//   req     | in  | irts_req_t  | valid/ready, taken when both high
//   res     | out | irts_res_t  | valid/ready, one result per request
//
// one request accepted per cycle when results are taken; each result
// passes through the s1 and output registers, buffer bytes via the ram's registered read
// control state updates at acceptance; buffer accesses never overlap on one edge
// reset clears the phase, counters and pipeline valid bits; buffer is not cleared
// a stalled result holds one request in flight behind it, then req.ready drops
module i2c_register_transfer_sequencer import irts_pkg::*; #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    irts_chan_if.sink    req,
    irts_chan_if.source  res
);
    localparam int AddrW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [8:0] BufLimit = 9'(BUFFER_BYTES);
    localparam logic [5:0] CountCap = 6'((BUFFER_BYTES < 63) ? BUFFER_BYTES : 63);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_START   = 3'd1;
    localparam logic [2:0] PH_TX      = 3'd2;
    localparam logic [2:0] PH_RESTART = 3'd3;
    localparam logic [2:0] PH_RX      = 3'd4;

    typedef struct packed {
        logic       tx_load;
        logic [7:0] tx_cmd;
        logic       tx_from_buf;
        logic       request_start;
        logic       request_stop;
        logic       receive_mode;
        logic       done_res;
        logic [1:0] status;
        logic [2:0] fault_code;
        logic       rd_from_buf;
    } stage_t;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [5:0] remain_reg, remain_next;
    logic [5:0] pos_reg, pos_next;
    logic       wmode_reg, wmode_next;

    logic       s1_valid_reg, s1_valid_next;
    stage_t     s1_reg, s1_next;
    logic       out_valid_reg, out_valid_next;
    irts_res_t  out_reg, out_next;

    logic             out_free;
    logic             s1_move;
    logic             accept;
    logic             buf_in_range;
    logic [5:0]       remain_dec;
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [AddrW-1:0] ram_raddr;
    logic [7:0]       ram_q;

    assign out_free  = !out_valid_reg || res.ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign accept    = req.valid && req.ready;

    assign buf_in_range = {4'b0, req.data.buf_addr} < BufLimit;
    assign remain_dec   = remain_reg - 6'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        wmode_next  = wmode_reg;
        s1_next     = '0;
        ram_we      = 1'b0;
        ram_waddr   = AddrW'(pos_reg);
        ram_wdata   = req.data.rx_data;
        ram_re      = 1'b0;
        ram_raddr   = AddrW'(pos_reg);

        case (req.data.action)
            ACT_START:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    s1_next.status = ST_BUSY;
                end
                else
                begin
                    cmd_next    = req.data.reg_address;
                    remain_next = (req.data.byte_count > CountCap) ? CountCap
                                                                   : req.data.byte_count;
                    wmode_next  = req.data.is_send;
                    pos_next    = '0;
                    phase_next  = PH_START;
                    s1_next.request_start = 1'b1;
                end
            end
            ACT_TX_READY:
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        s1_next.tx_load = 1'b1;
                        s1_next.tx_cmd  = cmd_reg;
                        phase_next      = wmode_reg ? PH_TX : PH_RESTART;
                    end
                    PH_RESTART:
                    begin
                        s1_next.request_start = 1'b1;
                        s1_next.receive_mode  = 1'b1;
                        s1_next.request_stop  = (remain_reg == 6'd1);
                        phase_next            = PH_RX;
                    end
                    PH_TX:
                    begin
                        if (remain_reg != 6'd0)
                        begin
                            s1_next.tx_load     = 1'b1;
                            s1_next.tx_from_buf = 1'b1;
                            ram_re      = 1'b1;
                            pos_next    = pos_reg + 6'd1;
                            remain_next = remain_dec;
                        end
                        else
                        begin
                            s1_next.request_stop = 1'b1;
                            s1_next.done_res     = 1'b1;
                            phase_next           = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        s1_next.status = ST_UNEXPECTED;
                    end
                endcase
            end
            ACT_RX_BYTE:
            begin
                if (phase_reg != PH_RX)
                begin
                    s1_next.status = ST_UNEXPECTED;
                end
                else
                begin
                    if (remain_reg != 6'd0)
                    begin
                        ram_we      = 1'b1;
                        pos_next    = pos_reg + 6'd1;
                        remain_next = remain_dec;
                    end
                    if (remain_next == 6'd1)
                    begin
                        s1_next.request_stop = 1'b1;
                    end
                    else if (remain_next == 6'd0)
                    begin
                        s1_next.done_res = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                end
            end
            ACT_FAULT:
            begin
                s1_next.status     = ST_FAULT;
                s1_next.fault_code = req.data.fault_kind;
                phase_next         = PH_IDLE;
            end
            ACT_BUF_WR:
            begin
                ram_we    = buf_in_range;
                ram_waddr = AddrW'(req.data.buf_addr);
                ram_wdata = req.data.buf_wdata;
            end
            ACT_BUF_RD:
            begin
                ram_re              = buf_in_range;
                ram_raddr           = AddrW'(req.data.buf_addr);
                s1_next.rd_from_buf = buf_in_range;
            end
            default:
            begin
                s1_next.status = ST_UNEXPECTED;
            end
        endcase

        if (!accept)
        begin
            ram_we = 1'b0;
            ram_re = 1'b0;
        end
    end

    irts_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        out_next.tx_load       = s1_reg.tx_load;
        out_next.tx_byte       = s1_reg.tx_from_buf ? ram_q : s1_reg.tx_cmd;
        out_next.request_start = s1_reg.request_start;
        out_next.request_stop  = s1_reg.request_stop;
        out_next.receive_mode  = s1_reg.receive_mode;
        out_next.done_res      = s1_reg.done_res;
        out_next.status        = s1_reg.status;
        out_next.fault_code    = s1_reg.fault_code;
        out_next.read_data     = s1_reg.rd_from_buf ? ram_q : 8'd0;

        s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= '0;
            remain_reg    <= '0;
            pos_reg       <= '0;
            wmode_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                cmd_reg    <= cmd_next;
                remain_reg <= remain_next;
                pos_reg    <= pos_next;
                wmode_reg  <= wmode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;
endmodule

### hw/rtl/irts_checker.sv
// irts_checker: port-level checks on the sequencer's request and result channels
// depends on irts_pkg; bound to i2c_register_transfer_sequencer below
module irts_checker import irts_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      res_valid,
    input logic      res_ready,
    input irts_res_t res_data
);
    logic [1:0] pend_reg, pend_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = req_valid && req_ready;
    assign out_take = res_valid && res_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_take} - {1'b0, out_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // at most two requests in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many requests in flight");

    // no result without a request behind it
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 2'd0)
        else $error("result with no pending request");

    // completion only on a clean end of transfer
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.done_res |->
            res_data.status == ST_OK && !res_data.request_start && !res_data.tx_load)
        else $error("completion flagged with wrong companions");

    // fault code only on a fault abort
    a_fcode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status != ST_FAULT |-> res_data.fault_code == 3'd0)
        else $error("fault code outside a fault abort");
endmodule

bind i2c_register_transfer_sequencer irts_checker u_irts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
